// ----- src/svsr_pkg.sv -----
package svsr_pkg;

    localparam int QUOT_W = 16;

    localparam logic [31:0] EASE_SCALE    = 32'd180000;
    localparam logic [15:0] RAMP_MS_SCALE = 16'd1000;

    localparam logic [1:0] CFG_MIN_PULSE  = 2'd0;
    localparam logic [1:0] CFG_MAX_PULSE  = 2'd1;
    localparam logic [1:0] CFG_PERIOD     = 2'd2;
    localparam logic [1:0] CFG_FULL_SCALE = 2'd3;

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_TICK = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_T_RT,
        S_T_E,
        S_T_GO,
        S_T_DIV,
        S_D_MIN,
        S_D_MAG,
        S_D_PER,
        S_D_FS,
        S_D_CHK,
        S_D_GO,
        S_D_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] angle_in;
        logic [15:0] rate_deg_per_s;
        logic [15:0] elapsed_ms;
        logic        eased;
    } t_in_word;

    typedef struct packed {
        logic [15:0] duty;
        logic        duty_valid;
        logic        rejected;
        logic [15:0] present_angle;
        logic        at_target;
    } t_out_word;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- src/svsr_mul.sv -----
module svsr_mul #(
    parameter int A_W = 36,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    logic [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- src/svsr_div.sv -----
module svsr_div #(
    parameter int DVD_W = 50,
    parameter int DSR_W = 33
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DVD_W-1:0]           i_dividend,
    input  logic [DSR_W-1:0]           i_divisor,
    output logic [svsr_pkg::QUOT_W-1:0] o_quot,
    output svsr_pkg::t_div_stat        o_stat
);

    localparam int CNT_W = $clog2(svsr_pkg::QUOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(svsr_pkg::QUOT_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [DVD_W-1:0]            r_rem;
    logic [DVD_W-1:0]            r_ds;
    logic [svsr_pkg::QUOT_W-1:0] r_q;
    logic                        fits;

    assign fits = r_rem >= r_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_ds  <= DVD_W'({i_divisor, {(svsr_pkg::QUOT_W - 1){1'b0}}});
            r_q   <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_ds;
            end
            r_q  <= {r_q[svsr_pkg::QUOT_W-2:0], fits};
            r_ds <= r_ds >> 1;
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ----- src/servo_slew_ramp_pwm_unit.sv -----
// Channel  Direction  Payload                 Handshake
// in       input      svsr_pkg::t_in_word     i_in_valid / o_in_stall
// out      output     svsr_pkg::t_out_word    o_out_valid / i_out_stall
// cfg      input      16-bit register data    i_cfg_we, i_cfg_index
//
// One word is worked at a time by a sequencer around one shared multiplier
// and one radix-2 divider that yields 16 quotient bits.
// Set-target and unused commands finish without the multiplier or divider, and a
// ramping tick spends most of its time in the two divider passes.
// Reset is synchronous and active low and restores the register defaults.
// The next input word is taken while a finished result waits on a stalled output.
module servo_slew_ramp_pwm_unit #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  svsr_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output svsr_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int DEN_W = F + 8;
    localparam int NUM_W = DEN_W + 16;
    localparam int A_W   = NUM_W;
    localparam int P_W   = A_W + 16;
    localparam int DVD_W = NUM_W + 18;
    localparam int DSR_W = DEN_W + 17;
    localparam int CMP_W = DEN_W + 16;
    localparam logic [DEN_W-1:0] DEN     = DEN_W'(180 * (1 << F));
    localparam logic [19:0]      ANG_ONE = 20'(1 << F);

    svsr_pkg::t_state    r_state, n_state;
    svsr_pkg::t_in_word  r_in, n_in;
    svsr_pkg::t_out_word r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [15:0] r_min, r_max, r_per, r_fs;
    logic [15:0] r_cur, n_cur;
    logic [15:0] r_tgt, n_tgt;
    logic [15:0] r_rate, n_rate;
    logic [15:0] r_gap, n_gap;
    logic        r_up, n_up;
    logic [31:0] r_rt, n_rt;
    logic        r_over, n_over;
    logic [NUM_W-1:0] r_acc, n_acc;
    logic [DEN_W+15:0] r_d, n_d;
    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DSR_W-1:0] r_dsr, n_dsr;
    logic [15:0] r_duty, n_duty;
    logic        r_send, n_send;
    logic        r_rej, n_rej;

    logic [A_W-1:0] mul_a;
    logic [15:0]    mul_b;
    logic [P_W-1:0] mul_p;
    logic           div_start;
    logic [svsr_pkg::QUOT_W-1:0] div_quot;
    svsr_pkg::t_div_stat div_stat;

    logic [15:0]    gap_now;
    logic           near_now;
    logic           ang_bad;
    logic [15:0]    mag;
    logic [15:0]    per_eff;
    logic [P_W-1:0] rt_shift;
    logic [NUM_W:0] num_up;

    svsr_mul #(
        .A_W(A_W),
        .B_W(16)
    ) u_mul (
        .i_clk(i_clk),
        .i_a  (mul_a),
        .i_b  (mul_b),
        .o_p  (mul_p)
    );

    svsr_div #(
        .DVD_W(DVD_W),
        .DSR_W(DSR_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_dvd),
        .i_divisor (r_dsr),
        .o_quot    (div_quot),
        .o_stat    (div_stat)
    );

    assign gap_now  = (r_tgt >= r_cur) ? (r_tgt - r_cur) : (r_cur - r_tgt);
    assign near_now = (20'(gap_now) * 20'd10) < ANG_ONE;
    assign ang_bad  = CMP_W'(r_in.angle_in) > CMP_W'(DEN);
    assign mag      = (r_max >= r_min) ? (r_max - r_min) : (r_min - r_max);
    assign per_eff  = (r_per == 16'd0) ? 16'd1 : r_per;
    assign rt_shift = P_W'({r_rt, {F{1'b0}}});
    assign num_up   = {1'b0, r_acc} + (NUM_W+1)'(mul_p[NUM_W-1:0]);

    assign o_in_stall  = r_state != svsr_pkg::S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svsr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 16'd500;
            r_max <= 16'd2500;
            r_per <= 16'd20000;
            r_fs  <= 16'd65535;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                svsr_pkg::CFG_MIN_PULSE:  r_min <= i_cfg_data;
                svsr_pkg::CFG_MAX_PULSE:  r_max <= i_cfg_data;
                svsr_pkg::CFG_PERIOD:     r_per <= i_cfg_data;
                svsr_pkg::CFG_FULL_SCALE: r_fs  <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_tgt       <= '0;
            r_rate      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_tgt       <= n_tgt;
            r_rate      <= n_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_out  <= n_out;
        r_gap  <= n_gap;
        r_up   <= n_up;
        r_rt   <= n_rt;
        r_over <= n_over;
        r_acc  <= n_acc;
        r_d    <= n_d;
        r_dvd  <= n_dvd;
        r_dsr  <= n_dsr;
        r_duty <= n_duty;
        r_send <= n_send;
        r_rej  <= n_rej;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_rate      = r_rate;
        n_gap       = r_gap;
        n_up        = r_up;
        n_rt        = r_rt;
        n_over      = r_over;
        n_acc       = r_acc;
        n_d         = r_d;
        n_dvd       = r_dvd;
        n_dsr       = r_dsr;
        n_duty      = r_duty;
        n_send      = r_send;
        n_rej       = r_rej;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;

        unique case (r_state)
            svsr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_word;
                    n_state = svsr_pkg::S_DECODE;
                end
            end
            svsr_pkg::S_DECODE: begin
                n_duty  = '0;
                n_send  = 1'b0;
                n_rej   = 1'b0;
                n_gap   = gap_now;
                n_up    = r_tgt > r_cur;
                n_state = svsr_pkg::S_DONE;
                unique case (r_in.command)
                    svsr_pkg::CMD_SET: begin
                        if (ang_bad || r_in.rate_deg_per_s == 16'd0) begin
                            n_rej = 1'b1;
                        end else begin
                            n_tgt  = r_in.angle_in;
                            n_rate = r_in.rate_deg_per_s;
                        end
                    end
                    svsr_pkg::CMD_MOVE: begin
                        if (ang_bad) begin
                            n_rej = 1'b1;
                        end else begin
                            n_cur   = r_in.angle_in;
                            n_send  = 1'b1;
                            n_state = svsr_pkg::S_D_MIN;
                        end
                    end
                    svsr_pkg::CMD_TICK: begin
                        if (r_in.elapsed_ms != 16'd0) begin
                            n_send = 1'b1;
                            if (near_now) begin
                                n_cur   = r_tgt;
                                n_state = svsr_pkg::S_D_MIN;
                            end else begin
                                mul_a   = A_W'(r_rate);
                                mul_b   = r_in.elapsed_ms;
                                n_state = svsr_pkg::S_T_RT;
                            end
                        end
                    end
                    default: begin
                        n_state = svsr_pkg::S_DONE;
                    end
                endcase
            end
            svsr_pkg::S_T_RT: begin
                n_rt = mul_p[31:0];
                if (r_in.eased) begin
                    mul_a = A_W'(mul_p[17:0]);
                    mul_b = r_gap;
                end else begin
                    mul_a = A_W'(r_gap);
                    mul_b = svsr_pkg::RAMP_MS_SCALE;
                end
                n_state = svsr_pkg::S_T_E;
            end
            svsr_pkg::S_T_E: begin
                if (r_in.eased) begin
                    n_over = r_rt > svsr_pkg::EASE_SCALE;
                    n_dvd  = DVD_W'(mul_p);
                    n_dsr  = DSR_W'(svsr_pkg::EASE_SCALE);
                end else begin
                    n_over = rt_shift > mul_p;
                    n_dvd  = DVD_W'(rt_shift);
                    n_dsr  = DSR_W'(svsr_pkg::RAMP_MS_SCALE);
                end
                n_state = svsr_pkg::S_T_GO;
            end
            svsr_pkg::S_T_GO: begin
                if (r_over) begin
                    n_cur   = r_tgt;
                    n_state = svsr_pkg::S_D_MIN;
                end else begin
                    div_start = 1'b1;
                    n_state   = svsr_pkg::S_T_DIV;
                end
            end
            svsr_pkg::S_T_DIV: begin
                if (div_stat.done) begin
                    if (div_quot >= r_gap) begin
                        n_cur = r_tgt;
                    end else if (r_up) begin
                        n_cur = r_cur + div_quot;
                    end else begin
                        n_cur = r_cur - div_quot;
                    end
                    n_state = svsr_pkg::S_D_MIN;
                end
            end
            svsr_pkg::S_D_MIN: begin
                mul_a   = A_W'(DEN);
                mul_b   = r_min;
                n_state = svsr_pkg::S_D_MAG;
            end
            svsr_pkg::S_D_MAG: begin
                n_acc   = mul_p[NUM_W-1:0];
                mul_a   = A_W'(r_cur);
                mul_b   = mag;
                n_state = svsr_pkg::S_D_PER;
            end
            svsr_pkg::S_D_PER: begin
                if (r_max >= r_min) begin
                    n_acc = num_up[NUM_W-1:0];
                end else if (r_acc >= mul_p[NUM_W-1:0]) begin
                    n_acc = r_acc - mul_p[NUM_W-1:0];
                end else begin
                    n_acc = '0;
                end
                mul_a   = A_W'(DEN);
                mul_b   = per_eff;
                n_state = svsr_pkg::S_D_FS;
            end
            svsr_pkg::S_D_FS: begin
                n_d     = mul_p[DEN_W+15:0];
                mul_a   = r_acc;
                mul_b   = r_fs;
                n_state = svsr_pkg::S_D_CHK;
            end
            svsr_pkg::S_D_CHK: begin
                n_dvd   = DVD_W'({mul_p, 1'b0}) + DVD_W'(r_d);
                n_dsr   = {r_d, 1'b0};
                n_state = svsr_pkg::S_D_GO;
            end
            svsr_pkg::S_D_GO: begin
                if (r_dvd >= DVD_W'({r_dsr, 16'b0})) begin
                    n_duty  = 16'hFFFF;
                    n_state = svsr_pkg::S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = svsr_pkg::S_D_DIV;
                end
            end
            svsr_pkg::S_D_DIV: begin
                if (div_stat.done) begin
                    n_duty  = div_quot;
                    n_state = svsr_pkg::S_DONE;
                end
            end
            svsr_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.duty          = r_send ? r_duty : 16'd0;
                    n_out.duty_valid    = r_send;
                    n_out.rejected      = r_rej;
                    n_out.present_angle = r_cur;
                    n_out.at_target     = near_now;
                    n_out_valid         = 1'b1;
                    n_state             = svsr_pkg::S_IDLE;
                end
            end
        endcase
    end

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_cur) <= CMP_W'(DEN))
        else $error("current angle beyond full travel");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == svsr_pkg::S_T_DIV || r_state == svsr_pkg::S_D_DIV))
        else $error("divider finished with no sequencer waiting");

    a_reject_no_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.rejected && r_out.duty_valid))
        else $error("rejected word carries a duty");

endmodule

// ----- test/servo_slew_ramp_pwm_unit_tb.sv -----
`timescale 1ns / 100ps

module servo_slew_ramp_pwm_unit_tb;
    localparam int FRAC = 8;
    localparam int unsigned ANGLE_ONE = 1 << FRAC;
    localparam int unsigned ANGLE_FULL = 180 << FRAC;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class servo_ramp_scoreboard;
        int unsigned min_pulse;
        int unsigned max_pulse;
        int unsigned period;
        int unsigned full_scale;
        int unsigned cur_angle;
        int unsigned tgt_angle;
        int unsigned ramp_rate;
        svsr_pkg::t_out_word awaited_words[$];
        int          errors;

        function new();
            min_pulse  = 500;
            max_pulse  = 2500;
            period     = 20000;
            full_scale = 65535;
            cur_angle  = 0;
            tgt_angle  = 0;
            ramp_rate  = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] value);
            case (index)
                svsr_pkg::CFG_MIN_PULSE:  min_pulse = 32'(value);
                svsr_pkg::CFG_MAX_PULSE:  max_pulse = 32'(value);
                svsr_pkg::CFG_PERIOD:     period = 32'(value);
                svsr_pkg::CFG_FULL_SCALE: full_scale = 32'(value);
                default: ;
            endcase
        endfunction

        function longint unsigned angle_gap();
            return (tgt_angle >= cur_angle) ? 64'(tgt_angle - cur_angle)
                                            : 64'(cur_angle - tgt_angle);
        endfunction

        function logic [15:0] duty_of(int unsigned angle);
            longint          num;
            longint unsigned per;
            longint unsigned den;
            longint unsigned q;
            num = longint'(min_pulse) * longint'(ANGLE_FULL)
                + (longint'(max_pulse) - longint'(min_pulse)) * longint'(angle);
            if (num < 0) begin
                num = 0;
            end
            per = (period == 0) ? 64'd1 : 64'(period);
            den = per * 64'(ANGLE_FULL);
            q = (64'd2 * unsigned'(num) * 64'(full_scale) + den) / (64'd2 * den);
            return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
        endfunction

        task report_mismatch(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        function void note_input(svsr_pkg::t_in_word w);
            logic                send;
            logic                rej;
            logic                over;
            longint unsigned     gap;
            longint unsigned     rt;
            longint unsigned     step;
            svsr_pkg::t_out_word want;
            send = 1'b0;
            rej = 1'b0;
            case (w.command)
                svsr_pkg::CMD_SET: begin
                    if (32'(w.angle_in) > ANGLE_FULL || w.rate_deg_per_s == 16'd0) begin
                        rej = 1'b1;
                    end else begin
                        tgt_angle = 32'(w.angle_in);
                        ramp_rate = 32'(w.rate_deg_per_s);
                    end
                end
                svsr_pkg::CMD_MOVE: begin
                    if (32'(w.angle_in) > ANGLE_FULL) begin
                        rej = 1'b1;
                    end else begin
                        cur_angle = 32'(w.angle_in);
                        send = 1'b1;
                    end
                end
                svsr_pkg::CMD_TICK: begin
                    if (w.elapsed_ms != 16'd0) begin
                        send = 1'b1;
                        gap = angle_gap();
                        if (gap * 64'd10 < 64'(ANGLE_ONE)) begin
                            cur_angle = tgt_angle;
                        end else begin
                            rt = 64'(ramp_rate) * 64'(w.elapsed_ms);
                            if (w.eased) begin
                                over = rt > 64'd180000;
                                step = rt * gap / 64'd180000;
                            end else begin
                                over = rt * 64'(ANGLE_ONE) > gap * 64'd1000;
                                step = rt * 64'(ANGLE_ONE) / 64'd1000;
                            end
                            if (over || step >= gap) begin
                                cur_angle = tgt_angle;
                            end else if (tgt_angle > cur_angle) begin
                                cur_angle = cur_angle + step[31:0];
                            end else begin
                                cur_angle = cur_angle - step[31:0];
                            end
                        end
                    end
                end
                default: ;
            endcase
            want.duty          = send ? duty_of(cur_angle) : 16'd0;
            want.duty_valid    = send;
            want.rejected      = rej;
            want.present_angle = cur_angle[15:0];
            want.at_target     = angle_gap() * 64'd10 < 64'(ANGLE_ONE);
            awaited_words.push_back(want);
        endfunction

        task check_result(svsr_pkg::t_out_word got);
            svsr_pkg::t_out_word want;
            if (awaited_words.size() == 0) begin
                report_mismatch("output word with nothing awaited");
            end else begin
                want = awaited_words.pop_front();
                if (got.duty !== want.duty)
                    report_mismatch($sformatf("duty %0d, want %0d", got.duty, want.duty));
                if (got.duty_valid !== want.duty_valid)
                    report_mismatch($sformatf("duty_valid %b, want %b",
                                              got.duty_valid, want.duty_valid));
                if (got.rejected !== want.rejected)
                    report_mismatch($sformatf("rejected %b, want %b",
                                              got.rejected, want.rejected));
                if (got.present_angle !== want.present_angle)
                    report_mismatch($sformatf("present_angle %0d, want %0d",
                                              got.present_angle, want.present_angle));
                if (got.at_target !== want.at_target)
                    report_mismatch($sformatf("at_target %b, want %b",
                                              got.at_target, want.at_target));
            end
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    svsr_pkg::t_in_word  in_word = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    svsr_pkg::t_out_word out_word;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = svsr_pkg::CFG_MIN_PULSE;
    logic [15:0]         cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    servo_ramp_scoreboard sb = new();

    servo_slew_ramp_pwm_unit #(
        .ANGLE_FRAC_BITS(FRAC)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver stalls at random, or for a long stretch when one is requested.
    always @(negedge clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else begin
            out_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_word);
        end
    end

    initial begin
        #16_000_000;
        $display("servo_slew_ramp_pwm_unit_tb: errors");
        $finish;
    end

    function automatic svsr_pkg::t_in_word make_word(logic [1:0] command, logic [15:0] angle,
                                                     logic [15:0] rate, logic [15:0] ms,
                                                     logic eased);
        svsr_pkg::t_in_word w;
        w.command        = command;
        w.angle_in       = angle;
        w.rate_deg_per_s = rate;
        w.elapsed_ms     = ms;
        w.eased          = eased;
        return w;
    endfunction

    function automatic svsr_pkg::t_in_word random_word();
        svsr_pkg::t_in_word w;
        int unsigned        pick;
        int unsigned        sel;
        w = make_word(svsr_pkg::CMD_TICK, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        sel = $urandom_range(0, 99);
        if (pick < 18) begin
            w.command = (pick < 12) ? svsr_pkg::CMD_SET : svsr_pkg::CMD_MOVE;
            w.angle_in = (sel < 10) ? 16'd0 :
                         (sel < 20) ? 16'(ANGLE_FULL) : 16'($urandom_range(0, ANGLE_FULL));
            w.rate_deg_per_s = (sel % 10 < 7) ? 16'($urandom_range(1, 400)) :
                               (sel % 10 < 9) ? 16'($urandom_range(1, 65535)) : 16'hFFFF;
        end else if (pick < 27) begin
            w.command = (pick < 24) ? svsr_pkg::CMD_SET : svsr_pkg::CMD_MOVE;
            if (w.command == svsr_pkg::CMD_MOVE || sel < 50) begin
                w.angle_in = 16'($urandom_range(ANGLE_FULL + 1, 65535));
            end else begin
                w.rate_deg_per_s = '0;
            end
        end else if (pick < 29) begin
            w.command = CMD_UNUSED;
        end else begin
            w.elapsed_ms = (sel < 5) ? 16'd0 :
                           (sel < 85) ? 16'($urandom_range(1, 60)) :
                                        16'($urandom_range(1, 65535));
        end
        return w;
    endfunction

    task automatic send_word(svsr_pkg::t_in_word w);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_word = w;
        do @(posedge clk); while (in_stall);
        sb.note_input(w);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(posedge clk);
        sb.write_reg(index, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(logic [15:0] min_us, logic [15:0] max_us,
                              logic [15:0] period_us, logic [15:0] full_scale);
        write_reg(svsr_pkg::CFG_MIN_PULSE, min_us);
        write_reg(svsr_pkg::CFG_MAX_PULSE, max_us);
        write_reg(svsr_pkg::CFG_PERIOD, period_us);
        write_reg(svsr_pkg::CFG_FULL_SCALE, full_scale);
    endtask

    task automatic wait_drained();
        while (sb.awaited_words.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial begin
        svsr_pkg::t_in_word w;
        int                 n;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 11;
                recv_idle_pct = 56;
            end else if (ph < 4) begin
                send_idle_pct = 56;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: ;
                1: set_config(16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
                2: set_config(16'hFFFF, 16'd0, 16'd0, 16'd1);
                4: set_config(16'd1000, 16'd2000, 16'd3030, 16'd1023);
                default: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            endcase
            if (ph == 0) begin
                send_word(make_word(svsr_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0, 1'b0));
                send_word(make_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
                send_word(make_word(svsr_pkg::CMD_SET, 16'(ANGLE_FULL + 1), 16'd10, 16'd5, 1'b0));
                send_word(make_word(svsr_pkg::CMD_SET, 16'd100, 16'd0, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_MOVE, 16'hFFFF, 16'd1, 16'd1, 1'b0));
                send_word(make_word(svsr_pkg::CMD_MOVE, 16'(ANGLE_FULL), 16'd0, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_MOVE, 16'd0, 16'd0, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_SET, 16'(ANGLE_FULL), 16'hFFFF, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_TICK, 16'd0, 16'd0, 16'hFFFF, 1'b0));
                send_word(make_word(svsr_pkg::CMD_SET, 16'd0, 16'd1, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_TICK, 16'd0, 16'd0, 16'd1, 1'b0));
                send_word(make_word(svsr_pkg::CMD_TICK, 16'd0, 16'd0, 16'd1, 1'b1));
                send_word(make_word(svsr_pkg::CMD_TICK, 16'd0, 16'd0, 16'd1000, 1'b1));
                send_word(make_word(svsr_pkg::CMD_MOVE, 16'd0, 16'd0, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_SET, 16'd25, 16'd5, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_TICK, 16'd0, 16'd0, 16'd1, 1'b0));
                send_word(make_word(svsr_pkg::CMD_SET, 16'(ANGLE_FULL), 16'd90, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_TICK, 16'd0, 16'd0, 16'd100, 1'b0));
                send_word(make_word(svsr_pkg::CMD_SET, 16'd0, 16'd90, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_TICK, 16'd0, 16'd0, 16'd2000, 1'b1));
                send_word(make_word(svsr_pkg::CMD_MOVE, 16'(ANGLE_FULL), 16'hFFFF, 16'hFFFF,
                                    1'b1));
                send_word(make_word(svsr_pkg::CMD_SET, 16'd0, 16'hFFFF, 16'd0, 1'b0));
                send_word(make_word(svsr_pkg::CMD_TICK, 16'd0, 16'd0, 16'hFFFF, 1'b1));
            end
            if (ph == 1) begin
                hold_req = 300;
            end
            n = 0;
            while (n < 205) begin
                w = random_word();
                send_word(w);
                if (w.command != CMD_UNUSED) begin
                    n++;
                end
            end
            @(negedge clk);
            in_valid = 1'b0;
            wait_drained();
        end
        if (sb.awaited_words.size() != 0) begin
            sb.report_mismatch("output words still awaited at the end");
        end
        if (sb.errors == 0) begin
            $display("servo_slew_ramp_pwm_unit_tb: clean");
        end else begin
            $display("servo_slew_ramp_pwm_unit_tb: errors");
        end
        $finish;
    end
endmodule

// ----- files.f -----
src/svsr_pkg.sv
src/svsr_mul.sv
src/svsr_div.sv
src/servo_slew_ramp_pwm_unit.sv
test/servo_slew_ramp_pwm_unit_tb.sv
